// ===== rtl/alisd_pkg.sv =====
// shared types, sizes and operation codes of the array list core
package alisd_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int DATA_W      = 32;
   localparam int POS_W       = 7;
   localparam int COUNT_W     = 7;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int GROUP_SIZE  = 8;
   localparam int NUM_GROUPS  = (MAX_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_CHANGE = 2'd2;
   localparam logic [1:0] ACT_FIND   = 2'd3;

   typedef logic [DATA_W-1:0] word_type;

   typedef struct packed {
      logic [1:0]               action;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] result_value;
      logic [COUNT_W-1:0]       count_after;
   } rsp_type;

   typedef struct packed {
      logic             ins;
      logic             del;
      logic             chg;
      logic             fnd;
      logic [CMP_W-1:0] pos0;
      logic [CMP_W-1:0] len;
      word_type         val;
   } cell_ctrl_type;

endpackage

// ===== rtl/array_list_insert_delete_search_core.sv =====
// top level of the array list core: control, cell row and hit tree
//
// Ordered list of up to MAX_ENTRIES signed 32-bit elements held in a row of
// cells. The request channel (req_valid, req_stall, req_data) carries one
// operation: insert, delete, change or find. The response channel
// (rsp_valid, rsp_stall, rsp_data) returns one result per request: success
// flag, deleted element or found 1-based position, and the new length.
// A request is taken only while the block is idle. The cycle after the
// transfer all cells flag hits against their current entries, the first
// level of the hit tree registers the first hit per group of eight cells,
// and all cells shift or overwrite in parallel. The next cycle picks the
// first group and loads the response register, which then drives the
// response channel. An operation runs through the cell update, the group
// pick, the response transfer and the return to idle before the next
// request is taken. While rsp_stall is high the response holds and no new
// request is taken. Reset empties the list and drops any pending
// response; entry contents are left as they are.
module array_list_insert_delete_search_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  alisd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output alisd_pkg::rsp_type rsp_data
);
   import alisd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_GROUP = 3'd2;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]       state_ff;
   logic [2:0]       state_in;
   req_type          req_ff;
   logic [CNT_W-1:0] len_ff;
   logic [CNT_W-1:0] len_in;
   logic             ok_ff;
   logic             ok_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   cell_ctrl_type    ctrl;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] len_ext;
   logic             exec;
   logic             pos_nonzero;

   word_type         entry_w [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] hit_w;
   logic             found;
   logic [IDX_W-1:0] found_index;
   word_type         found_data;

   logic             req_xfer;
   logic             rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   assign exec        = (state_ff == ST_EXEC);
   assign pos_ext     = CMP_W'(req_ff.position);
   assign len_ext     = CMP_W'(len_ff);
   assign pos_nonzero = (pos_ext != '0);

   always_comb begin
      ctrl.ins  = exec && (req_ff.action == ACT_INSERT) && pos_nonzero &&
                  (pos_ext <= len_ext + CMP_W'(1)) && (len_ext < CMP_W'(MAX_ENTRIES));
      ctrl.del  = exec && (req_ff.action == ACT_DELETE) && pos_nonzero &&
                  (pos_ext <= len_ext);
      ctrl.chg  = exec && (req_ff.action == ACT_CHANGE) && pos_nonzero &&
                  (pos_ext <= len_ext);
      ctrl.fnd  = exec && (req_ff.action == ACT_FIND);
      ctrl.pos0 = pos_ext - CMP_W'(1);
      ctrl.len  = len_ext;
      ctrl.val  = req_ff.value;
   end

   genvar i;
   generate
      for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
         word_type left_w;
         word_type right_w;
         if (i == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_left
            assign left_w = entry_w[i-1];
         end
         if (i == MAX_ENTRIES - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_right
            assign right_w = entry_w[i+1];
         end
         alisd_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .cell_index (IDX_W'(i)),
            .left_data  (left_w),
            .right_data (right_w),
            .entry      (entry_w[i]),
            .hit        (hit_w[i])
         );
      end
   endgenerate

   alisd_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .hits        (hit_w),
      .entry_data  (entry_w),
      .found       (found),
      .found_index (found_index),
      .found_data  (found_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_xfer) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_GROUP;
         ST_GROUP: state_in = ST_OUT;
         ST_OUT:   if (rsp_xfer) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      len_in = len_ff;
      if (ctrl.ins) begin
         len_in = len_ff + CNT_W'(1);
      end else if (ctrl.del) begin
         len_in = len_ff - CNT_W'(1);
      end
      ok_in = ok_ff;
      if (exec) begin
         ok_in = ctrl.ins || ctrl.del || ctrl.chg;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (state_ff == ST_GROUP) begin
         rsp_in.count_after  = COUNT_W'(len_ff);
         rsp_in.result_value = '0;
         if (req_ff.action == ACT_FIND) begin
            rsp_in.ok = found;
            if (found) begin
               rsp_in.result_value = DATA_W'(found_index) + DATA_W'(1);
            end
         end else begin
            rsp_in.ok = ok_ff;
            if ((req_ff.action == ACT_DELETE) && ok_ff) begin
               rsp_in.result_value = found_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_data;
      end
      ok_ff  <= ok_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(len_ff) <= CMP_W'(MAX_ENTRIES))
      else $error("list length above capacity");

   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a response is pending");

   a_xfer_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_EXEC))
      else $error("request transfer did not start execution");

   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins |=> (len_ff == $past(len_ff) + CNT_W'(1)))
      else $error("insert did not grow the list");

   a_del_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.del |=> (len_ff == $past(len_ff) - CNT_W'(1)))
      else $error("delete did not shrink the list");
`endif

endmodule

// ===== rtl/alisd_cell.sv =====
// one list slot: holds an entry, shifts with its neighbors, flags a hit
module alisd_cell (
   input  logic                    clock,
   input  alisd_pkg::cell_ctrl_type ctrl,
   input  logic [alisd_pkg::IDX_W-1:0] cell_index,
   input  alisd_pkg::word_type     left_data,
   input  alisd_pkg::word_type     right_data,
   output alisd_pkg::word_type     entry,
   output logic                    hit
);
   import alisd_pkg::*;

   word_type         data_ff;
   word_type         data_in;
   logic             hit_in;
   logic [CMP_W-1:0] idx_ext;

   assign idx_ext = CMP_W'(cell_index);

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (idx_ext > ctrl.pos0) begin
            data_in = left_data;
         end else if (idx_ext == ctrl.pos0) begin
            data_in = ctrl.val;
         end
      end
      if (ctrl.del && (idx_ext >= ctrl.pos0)) begin
         data_in = right_data;
      end
      if (ctrl.chg && (idx_ext == ctrl.pos0)) begin
         data_in = ctrl.val;
      end
      // hit is flagged against the entry as it stands before the update
      hit_in = (ctrl.del && (idx_ext == ctrl.pos0)) ||
               (ctrl.fnd && (idx_ext < ctrl.len) && (data_ff == ctrl.val));
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry = data_ff;
   assign hit   = hit_in;

endmodule

// ===== rtl/alisd_reduce.sv =====
// registered first-hit tree over the cell row
module alisd_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [alisd_pkg::MAX_ENTRIES-1:0] hits,
   input  alisd_pkg::word_type         entry_data [alisd_pkg::MAX_ENTRIES],
   output logic                        found,
   output logic [alisd_pkg::IDX_W-1:0] found_index,
   output alisd_pkg::word_type         found_data
);
   import alisd_pkg::*;

   logic             grp_hit_ff  [NUM_GROUPS];
   logic             grp_hit_in  [NUM_GROUPS];
   logic [IDX_W-1:0] grp_idx_ff  [NUM_GROUPS];
   logic [IDX_W-1:0] grp_idx_in  [NUM_GROUPS];
   word_type         grp_data_ff [NUM_GROUPS];
   word_type         grp_data_in [NUM_GROUPS];

   // first hit inside each group of cells
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_hit_in[g]  = 1'b0;
         grp_idx_in[g]  = '0;
         grp_data_in[g] = '0;
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if ((g * GROUP_SIZE + j) < MAX_ENTRIES) begin
               if (hits[g * GROUP_SIZE + j]) begin
                  grp_hit_in[g]  = 1'b1;
                  grp_idx_in[g]  = IDX_W'(g * GROUP_SIZE + j);
                  grp_data_in[g] = entry_data[g * GROUP_SIZE + j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_idx_ff[g]  <= grp_idx_in[g];
         grp_data_ff[g] <= grp_data_in[g];
         if (reset) begin
            grp_hit_ff[g] <= 1'b0;
         end else begin
            grp_hit_ff[g] <= grp_hit_in[g];
         end
      end
   end

   // first group with a hit
   always_comb begin
      found       = 1'b0;
      found_index = '0;
      found_data  = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            found       = 1'b1;
            found_index = grp_idx_ff[g];
            found_data  = grp_data_ff[g];
         end
      end
   end

endmodule
